// ----- rtl/core/gdfw_pkg.sv -----
// Shared types and codes for the depth-first graph walk core.
`default_nettype none

package gdfw_pkg;

    localparam int NODE_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_WALK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } req_item_t;

    typedef struct packed {
        logic [NODE_W-1:0]   visited_node;
        logic                last;
        logic [STATUS_W-1:0] status;
    } rsp_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/gdfw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gdfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/graph_depth_first_walk_core.sv -----
// Top level of the depth-first graph walk core: neighbor lists, degrees, walk stack.
//
//  channel | direction | handshake        | beat
//  --------+-----------+------------------+--------------------------------------
//  req     | in        | req_valid/stall  | operation, node_a, node_b
//  rsp     | out       | rsp_valid/stall  | visited_node, last, status
//  cfg     | in        | cfg_valid/ready  | node_count
//
//  Add edge makes two degree reads on the one degree RAM port and ends early on a full list.
//  A walk scans neighbor list entries through the one read port of the neighbor RAM;
//  one item is worked on at a time.
//  Reset needs no clearing pass: degree valid bits and visited marks clear at once.
//  A stalled rsp holds the engine only when it has another beat to present.
`default_nettype none

module graph_depth_first_walk_core #(
    parameter int MAX_NODES  = 64,
    parameter int MAX_DEGREE = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire gdfw_pkg::req_item_t               req,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output gdfw_pkg::rsp_item_t                    rsp,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gdfw_pkg::COUNT_W-1:0]      cfg_data
);

    import gdfw_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int DCW = $clog2(MAX_DEGREE + 1);
    localparam int SDW = $clog2(MAX_NODES + 1);
    localparam int NBR_DEPTH = MAX_NODES * MAX_DEGREE;
    localparam int AW  = NBR_DEPTH > 1 ? $clog2(NBR_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_A,
        S_ADD_B,
        S_ADD_W,
        S_EMIT,
        S_POP,
        S_POPD,
        S_DEG,
        S_SCAN
    } state_t;

    state_t                  state_reg;
    req_item_t               req_reg;
    logic [COUNT_W-1:0]      node_count_reg;
    logic [MAX_NODES-1:0]    deg_vld_reg;
    logic [MAX_NODES-1:0]    visited_reg;
    logic                    deg_rd_vld_reg;
    logic [DCW-1:0]          deg_a_reg;
    logic [DCW-1:0]          deg_b_reg;
    logic [DCW-1:0]          deg_cnt_reg;
    logic [DCW-1:0]          idx_reg;
    logic [SDW-1:0]          depth_reg;
    logic [NW-1:0]           cur_node_reg;
    logic                    have_pending_reg;
    logic [STATUS_W-1:0]     res_status_reg;
    logic                    rsp_valid_reg;
    rsp_item_t               rsp_reg;

    logic [NW-1:0]           a_idx;
    logic [NW-1:0]           b_idx;
    logic                    ok_a;
    logic                    ok_b;
    logic                    out_free;
    logic                    rsp_load;
    logic [DCW-1:0]          deg_rd;
    logic                    add_full;
    logic                    push;
    logic [DCW-1:0]          deg_a_inc;

    logic                    deg_we;
    logic [NW-1:0]           deg_waddr;
    logic [DCW-1:0]          deg_wdata;
    logic [NW-1:0]           deg_raddr;
    logic [DCW-1:0]          deg_rdata;

    logic                    nbr_we;
    logic [AW-1:0]           nbr_waddr;
    logic [NW-1:0]           nbr_wdata;
    logic [AW-1:0]           nbr_raddr;
    logic [NW-1:0]           nbr_rdata;

    logic                    stk_we;
    logic [NW-1:0]           stk_waddr;
    logic [NW-1:0]           stk_wdata;
    logic [NW-1:0]           stk_raddr;
    logic [NW-1:0]           stk_rdata;

    function automatic logic id_ok(input logic [NODE_W-1:0] id,
                                   input logic [COUNT_W-1:0] cnt);
        return (COUNT_W'(id) < cnt) && (COUNT_W'(id) < COUNT_W'(MAX_NODES));
    endfunction

    assign a_idx     = req_reg.node_a[NW-1:0];
    assign b_idx     = req_reg.node_b[NW-1:0];
    assign ok_a      = id_ok(req_reg.node_a, node_count_reg);
    assign ok_b      = id_ok(req_reg.node_b, node_count_reg);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_load  = out_free && ((state_reg == S_EMIT)
                       || (state_reg == S_POP && (depth_reg == '0 || have_pending_reg)));
    assign deg_rd    = deg_rd_vld_reg ? deg_rdata : '0;
    assign deg_a_inc = deg_a_reg + DCW'(1);
    assign push      = !visited_reg[nbr_rdata] && (depth_reg < SDW'(MAX_NODES));

    always_comb
    begin
        if (a_idx == b_idx)
        begin
            add_full = ({1'b0, deg_a_reg} + (DCW+1)'(2)) > (DCW+1)'(MAX_DEGREE);
        end
        else
        begin
            add_full = (deg_a_reg >= DCW'(MAX_DEGREE)) || (deg_rd >= DCW'(MAX_DEGREE));
        end
    end

    always_comb
    begin
        deg_we    = 1'b0;
        deg_waddr = a_idx;
        deg_wdata = deg_a_inc;
        deg_raddr = a_idx;
        nbr_we    = 1'b0;
        nbr_waddr = AW'(a_idx) * AW'(MAX_DEGREE) + AW'(deg_a_reg);
        nbr_wdata = b_idx;
        nbr_raddr = AW'(cur_node_reg) * AW'(MAX_DEGREE) + AW'(idx_reg);
        stk_we    = 1'b0;
        stk_waddr = depth_reg[NW-1:0];
        stk_wdata = nbr_rdata;
        stk_raddr = NW'(depth_reg - SDW'(1));
        unique case (state_reg)
            S_DECODE:
            begin
                if (req_reg.operation == OP_WALK && ok_a)
                begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = a_idx;
                end
            end
            S_ADD_A:
            begin
                deg_raddr = b_idx;
            end
            S_ADD_B:
            begin
                deg_raddr = b_idx;
                if (!add_full)
                begin
                    deg_we = 1'b1;
                    nbr_we = 1'b1;
                end
            end
            S_ADD_W:
            begin
                deg_we    = 1'b1;
                deg_waddr = b_idx;
                deg_wdata = deg_b_reg + DCW'(1);
                nbr_we    = 1'b1;
                nbr_waddr = AW'(b_idx) * AW'(MAX_DEGREE) + AW'(deg_b_reg);
                nbr_wdata = a_idx;
            end
            S_POPD:
            begin
                deg_raddr = stk_rdata;
            end
            S_SCAN:
            begin
                stk_we = push;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            node_count_reg   <= NODE_COUNT_RESET;
            deg_vld_reg      <= '0;
            visited_reg      <= '0;
            deg_rd_vld_reg   <= 1'b0;
            depth_reg        <= '0;
            have_pending_reg <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            deg_rd_vld_reg <= deg_vld_reg[deg_raddr];
            if (deg_we)
            begin
                deg_vld_reg[deg_waddr] <= 1'b1;
            end
            if (cfg_valid)
            begin
                node_count_reg <= cfg_data;
            end
            rsp_valid_reg <= rsp_load || (rsp_valid_reg && rsp_stall);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg   <= req;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    unique case (req_reg.operation)
                        OP_ADD:
                        begin
                            if (ok_a && ok_b)
                            begin
                                state_reg <= S_ADD_A;
                            end
                            else
                            begin
                                res_status_reg <= ST_RANGE;
                                state_reg      <= S_EMIT;
                            end
                        end
                        OP_WALK:
                        begin
                            if (ok_a)
                            begin
                                visited_reg      <= MAX_NODES'(1) << a_idx;
                                depth_reg        <= SDW'(1);
                                have_pending_reg <= 1'b0;
                                state_reg        <= S_POP;
                            end
                            else
                            begin
                                res_status_reg <= ST_RANGE;
                                state_reg      <= S_EMIT;
                            end
                        end
                        OP_CLEAR:
                        begin
                            deg_vld_reg    <= '0;
                            res_status_reg <= ST_OK;
                            state_reg      <= S_EMIT;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_ADD_A:
                begin
                    deg_a_reg <= deg_rd;
                    state_reg <= S_ADD_B;
                end
                S_ADD_B:
                begin
                    if (add_full)
                    begin
                        res_status_reg <= ST_FULL;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        deg_b_reg <= (a_idx == b_idx) ? deg_a_inc : deg_rd;
                        state_reg <= S_ADD_W;
                    end
                end
                S_ADD_W:
                begin
                    res_status_reg <= ST_OK;
                    state_reg      <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        rsp_reg.visited_node <= '0;
                        rsp_reg.last         <= 1'b1;
                        rsp_reg.status       <= res_status_reg;
                        state_reg            <= S_IDLE;
                    end
                end
                S_POP:
                begin
                    if (depth_reg == '0)
                    begin
                        if (out_free)
                        begin
                            rsp_reg.visited_node <= NODE_W'(cur_node_reg);
                            rsp_reg.last         <= 1'b1;
                            rsp_reg.status       <= ST_OK;
                            have_pending_reg     <= 1'b0;
                            state_reg            <= S_IDLE;
                        end
                    end
                    else if (out_free || !have_pending_reg)
                    begin
                        if (have_pending_reg)
                        begin
                            rsp_reg.visited_node <= NODE_W'(cur_node_reg);
                            rsp_reg.last         <= 1'b0;
                            rsp_reg.status       <= ST_OK;
                        end
                        depth_reg <= depth_reg - SDW'(1);
                        state_reg <= S_POPD;
                    end
                end
                S_POPD:
                begin
                    cur_node_reg     <= stk_rdata;
                    have_pending_reg <= 1'b1;
                    idx_reg          <= '0;
                    state_reg        <= S_DEG;
                end
                S_DEG:
                begin
                    deg_cnt_reg <= deg_rd;
                    if (deg_rd == '0)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        idx_reg   <= DCW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (push)
                    begin
                        visited_reg[nbr_rdata] <= 1'b1;
                        depth_reg              <= depth_reg + SDW'(1);
                    end
                    if (idx_reg < deg_cnt_reg)
                    begin
                        idx_reg <= idx_reg + DCW'(1);
                    end
                    else
                    begin
                        state_reg <= S_POP;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    gdfw_ram #(
        .WIDTH (DCW),
        .DEPTH (MAX_NODES)
    ) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    gdfw_ram #(
        .WIDTH (NW),
        .DEPTH (NBR_DEPTH)
    ) u_nbr_ram (
        .clk   (clk),
        .we    (nbr_we),
        .waddr (nbr_waddr),
        .wdata (nbr_wdata),
        .raddr (nbr_raddr),
        .rdata (nbr_rdata)
    );

    gdfw_ram #(
        .WIDTH (NW),
        .DEPTH (MAX_NODES)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= SDW'(MAX_NODES))
        else $error("walk stack depth beyond node capacity");

    a_popped_marked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DEG |-> visited_reg[cur_node_reg])
        else $error("popped node was never marked");

    a_list_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADD_W |-> deg_b_reg < DCW'(MAX_DEGREE))
        else $error("neighbor list write past its capacity");

    a_pending_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP && depth_reg == '0 |-> have_pending_reg)
        else $error("walk ended with no node to flag last");
`endif

endmodule

`default_nettype wire
